// ----- design/assert_macros.svh -----
// Assertion macros used by the checker file.
// Each macro samples on the rising edge of clk_i and is off while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define AKVT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define AKVT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/akvt_pkg.sv -----
`timescale 1ns / 1ps
package akvt_pkg;

  localparam int KEY_W     = 32;
  localparam int VALUE_W   = 32;
  localparam int STAMP_W   = 32;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 1;
  localparam int COUNT_W   = 5;

  localparam logic [COUNT_W-1:0] COUNT_MAX          = '1;
  localparam logic [CFG_W-1:0]   EXPIRY_AGE_RST     = 16'd1000;
  localparam logic [CFG_W-1:0]   SWEEP_INTERVAL_RST = 16'd1000;

  typedef enum logic [1:0] {
    OP_GET  = 2'd0,
    OP_SET  = 2'd1,
    OP_TICK = 2'd2
  } opcode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_EXPIRY_AGE     = 1'b0,
    REG_SWEEP_INTERVAL = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [KEY_W-1:0]   key;
    logic [VALUE_W-1:0] value;
  } in_word_t;

  typedef struct packed {
    logic               hit;
    logic [VALUE_W-1:0] read_value;
    logic               evicted;
    logic [COUNT_W-1:0] expired_count;
  } out_word_t;

  // Control from the sequencer to the scan datapath.
  typedef struct packed {
    logic clear;
    logic sample;
    logic sweep;
  } scan_ctrl_t;

  // Status from the scan datapath back to the sequencer.
  typedef struct packed {
    logic hit;
    logic free_found;
    logic expire_now;
  } scan_flags_t;

endpackage

// ----- design/akvt_mem.sv -----
`timescale 1ns / 1ps
module akvt_mem #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 96
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/akvt_scan.sv -----
`timescale 1ns / 1ps
module akvt_scan #(
  parameter int ENTRIES    = 16,
  parameter int KEY_BITS   = 32,
  parameter int VALUE_BITS = 32
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  akvt_pkg::scan_ctrl_t             ctrl_i,
  input  logic [$clog2(ENTRIES)-1:0]       smp_idx_i,
  input  logic                             smp_valid_i,
  input  logic [KEY_BITS-1:0]              smp_key_i,
  input  logic [VALUE_BITS-1:0]            smp_data_i,
  input  logic [akvt_pkg::STAMP_W-1:0]     smp_stamp_i,
  input  logic [KEY_BITS-1:0]              key_i,
  input  logic [akvt_pkg::STAMP_W-1:0]     now_i,
  input  logic [akvt_pkg::CFG_W-1:0]       expiry_i,
  output akvt_pkg::scan_flags_t            flags_o,
  output logic [$clog2(ENTRIES)-1:0]       hit_idx_o,
  output logic [VALUE_BITS-1:0]            hit_data_o,
  output logic [$clog2(ENTRIES)-1:0]       free_idx_o,
  output logic [$clog2(ENTRIES)-1:0]       old_idx_o,
  output logic [akvt_pkg::COUNT_W-1:0]     expired_cnt_o
);

  import akvt_pkg::*;

  localparam int IW = $clog2(ENTRIES);

  logic               hit_q, hit_d;
  logic [IW-1:0]      hit_idx_q, hit_idx_d;
  logic [VALUE_BITS-1:0] hit_data_q, hit_data_d;
  logic               free_q, free_d;
  logic [IW-1:0]      free_idx_q, free_idx_d;
  logic               old_q, old_d;
  logic [IW-1:0]      old_idx_q, old_idx_d;
  logic [STAMP_W-1:0] old_age_q, old_age_d;
  logic [COUNT_W-1:0] cnt_q, cnt_d;

  logic [STAMP_W-1:0] age;
  logic               match;
  logic               expire;

  // Age wraps with the tick counter.
  assign age    = now_i - smp_stamp_i;
  assign match  = smp_valid_i && (smp_key_i == key_i);
  assign expire = ctrl_i.sample && ctrl_i.sweep && smp_valid_i &&
                  (age > STAMP_W'(expiry_i));

  always_comb begin
    hit_d      = hit_q;
    hit_idx_d  = hit_idx_q;
    hit_data_d = hit_data_q;
    free_d     = free_q;
    free_idx_d = free_idx_q;
    old_d      = old_q;
    old_idx_d  = old_idx_q;
    old_age_d  = old_age_q;
    cnt_d      = cnt_q;
    if (ctrl_i.clear) begin
      hit_d  = 1'b0;
      free_d = 1'b0;
      old_d  = 1'b0;
      cnt_d  = '0;
    end else if (ctrl_i.sample) begin
      if (match && !hit_q) begin
        hit_d      = 1'b1;
        hit_idx_d  = smp_idx_i;
        hit_data_d = smp_data_i;
      end
      if (!smp_valid_i && !free_q) begin
        free_d     = 1'b1;
        free_idx_d = smp_idx_i;
      end
      // Strictly greater, so ties keep the lower slot seen first.
      if (smp_valid_i && (!old_q || (age > old_age_q))) begin
        old_d     = 1'b1;
        old_idx_d = smp_idx_i;
        old_age_d = age;
      end
      if (expire && (cnt_q != COUNT_MAX)) begin
        cnt_d = cnt_q + COUNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q  <= 1'b0;
      free_q <= 1'b0;
      old_q  <= 1'b0;
      cnt_q  <= '0;
    end else begin
      hit_q  <= hit_d;
      free_q <= free_d;
      old_q  <= old_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hit_idx_q  <= hit_idx_d;
    hit_data_q <= hit_data_d;
    free_idx_q <= free_idx_d;
    old_idx_q  <= old_idx_d;
    old_age_q  <= old_age_d;
  end

  assign flags_o.hit        = hit_q;
  assign flags_o.free_found = free_q;
  assign flags_o.expire_now = expire;
  assign hit_idx_o          = hit_idx_q;
  assign hit_data_o         = hit_data_q;
  assign free_idx_o         = free_idx_q;
  assign old_idx_o          = old_idx_q;
  assign expired_cnt_o      = cnt_q;

endmodule

// ----- design/aging_key_value_table_unit.sv -----
`timescale 1ns / 1ps
// Channel   Ports                                   Handshake
// command   start, busy, cmd_i                      taken when start is high and busy is low
// result    result_valid_o, result_o                shown for one cycle, cannot be held off
// config    cfg_we_i, cfg_idx_i, cfg_data_i         written when cfg_we_i is high
//
// A get, a set, or a tick that triggers an expiry sweep walks every slot of the
// table memory once, one read per cycle, and passes through ST_LAST and
// ST_FINISH before it raises the result strobe. A tick with no sweep and an
// unused opcode raise the result strobe at the accepting edge. The next word
// may be started in the same cycle that the result strobe is shown. Reset empties
// the table at once through the per-slot valid flags; there is no clearing pass.
module aging_key_value_table_unit #(
  parameter int ENTRIES    = 16,
  parameter int KEY_BITS   = 32,
  parameter int VALUE_BITS = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  akvt_pkg::in_word_t                cmd_i,
  output logic                              result_valid_o,
  output akvt_pkg::out_word_t               result_o,
  input  logic                              cfg_we_i,
  input  logic [akvt_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [akvt_pkg::CFG_W-1:0]        cfg_data_i
);

  import akvt_pkg::*;

  localparam int IW     = $clog2(ENTRIES);
  localparam int KIN    = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;
  localparam int VIN    = (VALUE_BITS < VALUE_W) ? VALUE_BITS : VALUE_W;
  localparam int WORD_W = KEY_BITS + VALUE_BITS + STAMP_W;
  localparam logic [IW-1:0] LAST_IDX = IW'(ENTRIES - 1);

  // The sequencer walks the memory in ST_SCAN, waits for the last read in
  // ST_LAST and commits the outcome in ST_FINISH.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_LAST,
    ST_FINISH
  } state_e;

  state_e              state_q, state_d;
  logic [IW-1:0]       addr_q, addr_d;
  logic                smp_vld_q;
  logic [IW-1:0]       smp_idx_q;
  logic [1:0]          op_q, op_d;
  logic [KEY_BITS-1:0] key_q, key_d;
  logic [VALUE_BITS-1:0] val_q, val_d;
  logic [STAMP_W-1:0]  now_q, now_d;
  logic [CFG_W-1:0]    tss_q, tss_d;
  logic [CFG_W-1:0]    expiry_q, expiry_d;
  logic [CFG_W-1:0]    interval_q, interval_d;
  logic [ENTRIES-1:0]  valid_q, valid_d;
  logic                busy_q, busy_d;
  logic                res_vld_q, res_vld_d;
  out_word_t           res_q, res_d;

  logic                accept;
  logic [CFG_W:0]      tick_next;
  logic [CFG_W-1:0]    interval_eff;
  logic [IW-1:0]       set_slot;

  scan_ctrl_t          scan_ctrl;
  scan_flags_t         scan_flags;
  logic [IW-1:0]       hit_idx;
  logic [VALUE_BITS-1:0] hit_data;
  logic [IW-1:0]       free_idx;
  logic [IW-1:0]       old_idx;
  logic [COUNT_W-1:0]  expired_cnt;

  logic                mem_we;
  logic [WORD_W-1:0]   mem_wdata;
  logic [WORD_W-1:0]   mem_rdata;

  assign accept = start && !busy_q;

  // A zero interval sweeps on every tick, the same as an interval of one.
  assign interval_eff = (interval_q == '0) ? CFG_W'(1) : interval_q;
  assign tick_next    = {1'b0, tss_q} + (CFG_W + 1)'(1);

  // A set reuses the slot of its key, else the lowest free slot, else the
  // oldest entry, which is evicted.
  assign set_slot = scan_flags.hit        ? hit_idx  :
                    scan_flags.free_found ? free_idx : old_idx;

  assign mem_wdata = {key_q, val_q, now_q};

  always_comb begin
    state_d    = state_q;
    addr_d     = addr_q;
    op_d       = op_q;
    key_d      = key_q;
    val_d      = val_q;
    now_d      = now_q;
    tss_d      = tss_q;
    expiry_d   = expiry_q;
    interval_d = interval_q;
    valid_d    = valid_q;
    busy_d     = busy_q;
    res_vld_d  = 1'b0;
    res_d      = res_q;
    mem_we     = 1'b0;
    scan_ctrl.clear  = 1'b0;
    scan_ctrl.sample = smp_vld_q;
    scan_ctrl.sweep  = (op_q == OP_TICK);

    if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_EXPIRY_AGE:     expiry_d   = cfg_data_i;
        REG_SWEEP_INTERVAL: interval_d = cfg_data_i;
        default: ;
      endcase
    end

    // Expired entries drop out as the sweep passes over them.
    if (scan_flags.expire_now) begin
      valid_d[smp_idx_q] = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          op_d  = cmd_i.opcode;
          key_d = KEY_BITS'(cmd_i.key[KIN-1:0]);
          val_d = VALUE_BITS'(cmd_i.value[VIN-1:0]);
          res_d = '0;
          case (cmd_i.opcode)
            OP_GET, OP_SET: begin
              scan_ctrl.clear = 1'b1;
              addr_d  = '0;
              state_d = ST_SCAN;
              busy_d  = 1'b1;
            end
            OP_TICK: begin
              // Time advances first; the sweep then sees the new time.
              now_d = now_q + STAMP_W'(1);
              if (tick_next >= {1'b0, interval_eff}) begin
                tss_d           = '0;
                scan_ctrl.clear = 1'b1;
                addr_d          = '0;
                state_d         = ST_SCAN;
                busy_d          = 1'b1;
              end else begin
                tss_d     = tick_next[CFG_W-1:0];
                res_vld_d = 1'b1;
              end
            end
            default: begin
              res_vld_d = 1'b1;
            end
          endcase
        end
      end
      ST_SCAN: begin
        addr_d = addr_q + IW'(1);
        if (addr_q == LAST_IDX) begin
          state_d = ST_LAST;
        end
      end
      ST_LAST: begin
        state_d = ST_FINISH;
      end
      ST_FINISH: begin
        state_d   = ST_IDLE;
        busy_d    = 1'b0;
        res_vld_d = 1'b1;
        case (op_q)
          OP_GET: begin
            res_d.hit        = scan_flags.hit;
            res_d.read_value = scan_flags.hit ? VALUE_W'(hit_data[VIN-1:0]) : '0;
          end
          OP_SET: begin
            mem_we            = 1'b1;
            valid_d[set_slot] = 1'b1;
            res_d.hit         = scan_flags.hit;
            res_d.evicted     = !scan_flags.hit && !scan_flags.free_found;
          end
          OP_TICK: begin
            res_d.expired_count = expired_cnt;
          end
          default: ;
        endcase
      end
      default: begin
        state_d = ST_IDLE;
        busy_d  = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      addr_q     <= '0;
      smp_vld_q  <= 1'b0;
      smp_idx_q  <= '0;
      op_q       <= '0;
      now_q      <= '0;
      tss_q      <= '0;
      expiry_q   <= EXPIRY_AGE_RST;
      interval_q <= SWEEP_INTERVAL_RST;
      valid_q    <= '0;
      busy_q     <= 1'b0;
      res_vld_q  <= 1'b0;
      res_q      <= '0;
    end else begin
      state_q    <= state_d;
      addr_q     <= addr_d;
      smp_vld_q  <= (state_q == ST_SCAN);
      smp_idx_q  <= addr_q;
      op_q       <= op_d;
      now_q      <= now_d;
      tss_q      <= tss_d;
      expiry_q   <= expiry_d;
      interval_q <= interval_d;
      valid_q    <= valid_d;
      busy_q     <= busy_d;
      res_vld_q  <= res_vld_d;
      res_q      <= res_d;
    end
  end

  // The command word needs no reset.
  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    val_q <= val_d;
  end

  // Each slot holds {key, data, stamp}; valid flags stay in flip-flops.
  akvt_mem #(
    .DEPTH (ENTRIES),
    .WIDTH (WORD_W)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (set_slot),
    .wdata_i (mem_wdata),
    .re_i    (state_q == ST_SCAN),
    .raddr_i (addr_q),
    .rdata_o (mem_rdata)
  );

  akvt_scan #(
    .ENTRIES    (ENTRIES),
    .KEY_BITS   (KEY_BITS),
    .VALUE_BITS (VALUE_BITS)
  ) u_scan (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctrl_i        (scan_ctrl),
    .smp_idx_i     (smp_idx_q),
    .smp_valid_i   (valid_q[smp_idx_q]),
    .smp_key_i     (mem_rdata[STAMP_W + VALUE_BITS +: KEY_BITS]),
    .smp_data_i    (mem_rdata[STAMP_W +: VALUE_BITS]),
    .smp_stamp_i   (mem_rdata[STAMP_W-1:0]),
    .key_i         (key_q),
    .now_i         (now_q),
    .expiry_i      (expiry_q),
    .flags_o       (scan_flags),
    .hit_idx_o     (hit_idx),
    .hit_data_o    (hit_data),
    .free_idx_o    (free_idx),
    .old_idx_o     (old_idx),
    .expired_cnt_o (expired_cnt)
  );

  assign busy           = busy_q;
  assign result_valid_o = res_vld_q;
  assign result_o       = res_q;

endmodule

// ----- design/akvt_checker.sv -----
`timescale 1ns / 1ps
`include "assert_macros.svh"
module akvt_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                start,
  input logic                busy,
  input akvt_pkg::in_word_t  cmd_i,
  input logic                result_valid_o,
  input akvt_pkg::out_word_t result_o
);

  import akvt_pkg::*;

  // Busy only rises after an accepted word.
  `AKVT_ASSERT_IMP(a_busy_from_start, $rose(busy), $past(start && !busy), "busy rose without a start")

  // A result is shown only once the unit is free again.
  `AKVT_ASSERT_IMP(a_result_not_busy, result_valid_o, !busy, "result shown while busy")

  // Every end of a busy period delivers its result.
  `AKVT_ASSERT_IMP(a_busy_ends_in_result, $fell(busy), result_valid_o, "busy fell without a result")

  // Lookups always walk the table.
  `AKVT_ASSERT_NXT(a_lookup_goes_busy, start && !busy && (cmd_i.opcode == OP_GET || cmd_i.opcode == OP_SET), busy, "get or set did not start a walk")

  // Sweep counts never come with lookup fields.
  `AKVT_ASSERT_IMP(a_fields_exclusive, result_valid_o && (result_o.expired_count != '0), !result_o.hit && !result_o.evicted && (result_o.read_value == '0), "sweep count mixed with lookup fields")

endmodule

bind aging_key_value_table_unit akvt_checker u_akvt_checker (.*);
